>>> rtl/core/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Types, codes and sizes shared by the indexed max-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int ID_COUNT_DEF = 1024;
  localparam int ID_W         = 10;
  localparam int SCORE_W      = 32;
  localparam int OCC_W        = 11;

  typedef enum logic [1:0] {
    REQ_SET     = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_REMOVE  = 2'd2,
    REQ_FLUSH   = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [ID_W-1:0]           lit_id;
    logic signed [SCORE_W-1:0] new_score;
  } in_t;

  typedef struct packed {
    logic                      hit;
    logic [ID_W-1:0]           out_id;
    logic signed [SCORE_W-1:0] out_score;
    logic [OCC_W-1:0]          occupancy;
  } out_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_SET1,
    ST_SU_RD,
    ST_SU_PSC,
    ST_SU_CMP,
    ST_SD_TOP,
    ST_SD_L,
    ST_SD_R,
    ST_SD_RS,
    ST_SD_CMP,
    ST_PLACE,
    ST_EX1,
    ST_EX2,
    ST_EX3,
    ST_RM1,
    ST_RM2,
    ST_RM3,
    ST_RM4,
    ST_RM5,
    ST_FL_RD,
    ST_FL_WR,
    ST_RESP
  } state_t;

endpackage

>>> rtl/core/imhq_mem.sv
// ----------------------------------------------------------------------------
// imhq_mem
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module imhq_mem #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/indexed_max_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_max_heap_queue
// Indexed binary max-heap of ids keyed by signed scores, with slot map.
// ----------------------------------------------------------------------------
// a miss goes straight to the result word; a set, extract or remove sifts up or down
//   the heap one level at a time, then places its id
// flush clears the slot map entry of each held id in turn; busy stays high through the result word
// throughput: one request at a time, next start accepted the cycle after the strobe
// reset: a clearing pass over every id zeroes slot map and scores
// the receiver cannot stall: each result word is shown for one cycle
module indexed_max_heap_queue #(
  parameter int ID_COUNT = imhq_pkg::ID_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  imhq_pkg::in_t   in_data,
  output logic            out_valid,
  output imhq_pkg::out_t  out_data
);

  localparam int IW = $clog2(ID_COUNT);
  localparam int PW = $clog2(ID_COUNT + 2);
  localparam int IDW = imhq_pkg::ID_W;
  localparam int SW = imhq_pkg::SCORE_W;

  imhq_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]        cnt_r, cnt_nxt, pos_r, pos_nxt, bpos_r, bpos_nxt;
  logic [IDW-1:0]       cur_id_r, cur_id_nxt, aux_id_r, aux_id_nxt;
  logic [IDW-1:0]       rid_r, rid_nxt, best_id_r, best_id_nxt, oid_r, oid_nxt;
  logic signed [SW-1:0] cur_sc_r, cur_sc_nxt, aux_sc_r, aux_sc_nxt;
  logic signed [SW-1:0] best_sc_r, best_sc_nxt, osc_r, osc_nxt;
  logic                 hit_r, hit_nxt;

  // memory ports
  logic           h_we, s_we, c_we;
  logic [IW-1:0]  h_wa, h_ra, s_wa, s_ra, c_wa, c_ra;
  logic [IDW-1:0] h_wd, h_rd;
  logic [PW-1:0]  s_wd, s_rd;
  logic [SW-1:0]  c_wd, c_rd;

  imhq_mem #(.W(IDW), .D(ID_COUNT)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );
  imhq_mem #(.W(PW), .D(ID_COUNT)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );
  imhq_mem #(.W(SW), .D(ID_COUNT)) u_score (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
  );

  logic          accept, id_ok;
  logic [PW:0]   cpos;
  logic          no_child, has_right;
  logic signed [SW-1:0] cmp_a, cmp_b;
  logic          gt;

  assign accept    = start && !busy;
  assign id_ok     = 32'(in_data.lit_id) < 32'(ID_COUNT);
  assign cpos      = {pos_r, 1'b0};
  assign no_child  = cpos > {1'b0, cnt_r};
  assign has_right = cpos < {1'b0, cnt_r};

  // shared signed comparator
  always_comb begin
    cmp_a = cur_sc_r;
    cmp_b = $signed(c_rd);
    unique case (state_r)
      imhq_pkg::ST_SD_RS: begin
        cmp_a = $signed(c_rd);
        cmp_b = aux_sc_r;
      end
      imhq_pkg::ST_SD_CMP: begin
        cmp_a = best_sc_r;
        cmp_b = cur_sc_r;
      end
      default: begin
        cmp_a = cur_sc_r;
        cmp_b = $signed(c_rd);
      end
    endcase
  end
  assign gt = cmp_a > cmp_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      imhq_pkg::ST_CLR:
        if (pos_r == PW'(ID_COUNT - 1)) state_nxt = imhq_pkg::ST_IDLE;
      imhq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (imhq_pkg::req_t'(in_data.req_type))
            imhq_pkg::REQ_SET:
              state_nxt = id_ok ? imhq_pkg::ST_SET1 : imhq_pkg::ST_RESP;
            imhq_pkg::REQ_EXTRACT:
              state_nxt = (cnt_r == '0) ? imhq_pkg::ST_RESP : imhq_pkg::ST_EX1;
            imhq_pkg::REQ_REMOVE:
              state_nxt = id_ok ? imhq_pkg::ST_RM1 : imhq_pkg::ST_RESP;
            default:
              state_nxt = imhq_pkg::ST_FL_RD;
          endcase
        end
      end
      imhq_pkg::ST_SET1: begin
        if (s_rd != '0) begin
          state_nxt = gt ? imhq_pkg::ST_SU_RD : imhq_pkg::ST_SD_TOP;
        end else begin
          state_nxt = (cnt_r < PW'(ID_COUNT)) ? imhq_pkg::ST_SU_RD : imhq_pkg::ST_RESP;
        end
      end
      imhq_pkg::ST_SU_RD:
        state_nxt = (pos_r <= PW'(1)) ? imhq_pkg::ST_PLACE : imhq_pkg::ST_SU_PSC;
      imhq_pkg::ST_SU_PSC: state_nxt = imhq_pkg::ST_SU_CMP;
      imhq_pkg::ST_SU_CMP: state_nxt = gt ? imhq_pkg::ST_SU_RD : imhq_pkg::ST_PLACE;
      imhq_pkg::ST_SD_TOP: state_nxt = no_child ? imhq_pkg::ST_PLACE : imhq_pkg::ST_SD_L;
      imhq_pkg::ST_SD_L:   state_nxt = imhq_pkg::ST_SD_R;
      imhq_pkg::ST_SD_R:
        state_nxt = has_right ? imhq_pkg::ST_SD_RS : imhq_pkg::ST_SD_CMP;
      imhq_pkg::ST_SD_RS:  state_nxt = imhq_pkg::ST_SD_CMP;
      imhq_pkg::ST_SD_CMP: state_nxt = gt ? imhq_pkg::ST_SD_TOP : imhq_pkg::ST_PLACE;
      imhq_pkg::ST_PLACE:  state_nxt = imhq_pkg::ST_RESP;
      imhq_pkg::ST_EX1:    state_nxt = imhq_pkg::ST_EX2;
      imhq_pkg::ST_EX2:
        state_nxt = (cnt_r > PW'(1)) ? imhq_pkg::ST_EX3 : imhq_pkg::ST_RESP;
      imhq_pkg::ST_EX3:    state_nxt = imhq_pkg::ST_SD_TOP;
      imhq_pkg::ST_RM1: begin
        if (s_rd == '0 || s_rd >= cnt_r) state_nxt = imhq_pkg::ST_RESP;
        else                             state_nxt = imhq_pkg::ST_RM2;
      end
      imhq_pkg::ST_RM2:    state_nxt = imhq_pkg::ST_RM3;
      imhq_pkg::ST_RM3:
        state_nxt = (pos_r > PW'(1)) ? imhq_pkg::ST_RM4 : imhq_pkg::ST_SD_TOP;
      imhq_pkg::ST_RM4:    state_nxt = imhq_pkg::ST_RM5;
      imhq_pkg::ST_RM5:    state_nxt = gt ? imhq_pkg::ST_SU_RD : imhq_pkg::ST_SD_TOP;
      imhq_pkg::ST_FL_RD:
        state_nxt = (pos_r > cnt_r) ? imhq_pkg::ST_RESP : imhq_pkg::ST_FL_WR;
      imhq_pkg::ST_FL_WR:  state_nxt = imhq_pkg::ST_FL_RD;
      imhq_pkg::ST_RESP:   state_nxt = imhq_pkg::ST_IDLE;
      default:             state_nxt = imhq_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt = cnt_r;       pos_nxt = pos_r;         bpos_nxt = bpos_r;
    cur_id_nxt = cur_id_r; aux_id_nxt = aux_id_r;   rid_nxt = rid_r;
    best_id_nxt = best_id_r;
    cur_sc_nxt = cur_sc_r; aux_sc_nxt = aux_sc_r;   best_sc_nxt = best_sc_r;
    hit_nxt = hit_r;       oid_nxt = oid_r;         osc_nxt = osc_r;
    h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    unique case (state_r)
      imhq_pkg::ST_CLR: begin
        s_we = 1'b1; s_wa = IW'(pos_r);
        c_we = 1'b1; c_wa = IW'(pos_r);
        pos_nxt = pos_r + 1'b1;
      end
      imhq_pkg::ST_IDLE: begin
        if (accept) begin
          hit_nxt = 1'b0; oid_nxt = '0; osc_nxt = '0;
          cur_id_nxt = in_data.lit_id;
          cur_sc_nxt = in_data.new_score;
          s_ra = IW'(in_data.lit_id);
          c_ra = IW'(in_data.lit_id);
          pos_nxt = PW'(1);
        end
      end
      imhq_pkg::ST_SET1: begin
        c_we = 1'b1; c_wa = IW'(cur_id_r); c_wd = cur_sc_r;
        if (s_rd != '0) begin
          pos_nxt = s_rd;
        end else if (cnt_r < PW'(ID_COUNT)) begin
          cnt_nxt = cnt_r + 1'b1;
          pos_nxt = cnt_r + 1'b1;
        end
      end
      imhq_pkg::ST_SU_RD:  h_ra = IW'((pos_r >> 1) - 1'b1);
      imhq_pkg::ST_SU_PSC: begin
        aux_id_nxt = h_rd;
        c_ra = IW'(h_rd);
      end
      imhq_pkg::ST_SU_CMP: begin
        if (gt) begin
          h_we = 1'b1; h_wa = IW'(pos_r - 1'b1); h_wd = aux_id_r;
          s_we = 1'b1; s_wa = IW'(aux_id_r);     s_wd = pos_r;
          pos_nxt = pos_r >> 1;
        end
      end
      imhq_pkg::ST_SD_TOP: h_ra = IW'(cpos - 1'b1);
      imhq_pkg::ST_SD_L: begin
        aux_id_nxt = h_rd;
        c_ra = IW'(h_rd);
        h_ra = IW'(cpos);
      end
      imhq_pkg::ST_SD_R: begin
        aux_sc_nxt  = $signed(c_rd);
        best_id_nxt = aux_id_r;
        best_sc_nxt = $signed(c_rd);
        bpos_nxt    = PW'(cpos);
        rid_nxt     = h_rd;
        c_ra        = IW'(h_rd);
      end
      imhq_pkg::ST_SD_RS: begin
        // left child keeps a tie
        if (gt) begin
          best_id_nxt = rid_r;
          best_sc_nxt = $signed(c_rd);
          bpos_nxt    = PW'(cpos + 1'b1);
        end
      end
      imhq_pkg::ST_SD_CMP: begin
        if (gt) begin
          h_we = 1'b1; h_wa = IW'(pos_r - 1'b1); h_wd = best_id_r;
          s_we = 1'b1; s_wa = IW'(best_id_r);    s_wd = pos_r;
          pos_nxt = bpos_r;
        end
      end
      imhq_pkg::ST_PLACE: begin
        h_we = 1'b1; h_wa = IW'(pos_r - 1'b1); h_wd = cur_id_r;
        s_we = 1'b1; s_wa = IW'(cur_id_r);     s_wd = pos_r;
      end
      imhq_pkg::ST_EX1: begin
        aux_id_nxt = h_rd;
        c_ra = IW'(h_rd);
        h_ra = IW'(cnt_r - 1'b1);
      end
      imhq_pkg::ST_EX2: begin
        hit_nxt = 1'b1;
        oid_nxt = aux_id_r;
        osc_nxt = $signed(c_rd);
        s_we = 1'b1; s_wa = IW'(aux_id_r);
        if (cnt_r > PW'(1)) begin
          cur_id_nxt = h_rd;
          c_ra = IW'(h_rd);
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          cnt_nxt = '0;
        end
      end
      imhq_pkg::ST_EX3: begin
        cur_sc_nxt = $signed(c_rd);
        pos_nxt = PW'(1);
      end
      imhq_pkg::ST_RM1: begin
        if (s_rd != '0) begin
          hit_nxt = 1'b1;
          s_we = 1'b1; s_wa = IW'(cur_id_r);
          pos_nxt = s_rd;
          if (s_rd >= cnt_r) cnt_nxt = cnt_r - 1'b1;
          else               h_ra = IW'(cnt_r - 1'b1);
        end
      end
      imhq_pkg::ST_RM2: begin
        cur_id_nxt = h_rd;
        c_ra = IW'(h_rd);
        cnt_nxt = cnt_r - 1'b1;
      end
      imhq_pkg::ST_RM3: begin
        cur_sc_nxt = $signed(c_rd);
        h_ra = IW'((pos_r >> 1) - 1'b1);
      end
      imhq_pkg::ST_RM4: c_ra = IW'(h_rd);
      imhq_pkg::ST_FL_RD: begin
        if (pos_r > cnt_r) cnt_nxt = '0;
        else               h_ra = IW'(pos_r - 1'b1);
      end
      imhq_pkg::ST_FL_WR: begin
        s_we = 1'b1; s_wa = IW'(h_rd);
        pos_nxt = pos_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imhq_pkg::ST_CLR;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bpos_r    <= bpos_nxt;
    cur_id_r  <= cur_id_nxt;
    aux_id_r  <= aux_id_nxt;
    rid_r     <= rid_nxt;
    best_id_r <= best_id_nxt;
    cur_sc_r  <= cur_sc_nxt;
    aux_sc_r  <= aux_sc_nxt;
    best_sc_r <= best_sc_nxt;
    hit_r     <= hit_nxt;
    oid_r     <= oid_nxt;
    osc_r     <= osc_nxt;
  end

  assign busy      = (state_r != imhq_pkg::ST_IDLE);
  assign out_valid = (state_r == imhq_pkg::ST_RESP);
  assign out_data  = '{hit: hit_r, out_id: oid_r, out_score: osc_r,
                       occupancy: imhq_pkg::OCC_W'(cnt_r)};

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not make the block busy");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit_r |-> oid_r == '0 && osc_r == '0)
    else $error("miss result carries id or score");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PW'(ID_COUNT))
    else $error("entry count beyond capacity");

endmodule
